/* rtl/palette_fade_engine_macros.svh */
// assertion macros shared by the checker
`ifndef PALETTE_FADE_ENGINE_MACROS_SVH
`define PALETTE_FADE_ENGINE_MACROS_SVH

// condition now implies consequence in the same cycle
`define PFE_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("palette fade check failed");

// condition now implies consequence in the next cycle
`define PFE_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("palette fade check failed");

`endif

/* rtl/pfe_pkg.sv */
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int CHANNELS        = 3;

    localparam int VAL_W       = 8;
    localparam int VOL_W       = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic [VOL_W-1:0] VOLUME_FULL = 7'd100;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_VOL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             moved;
    } chan_result_t;

endpackage

/* rtl/palette_fade_engine.sv */
`timescale 1ns / 1ps

// Palette fade engine.
// Input words on s_axis: tuser carries the kind (load, start, tick, read),
// tdata the entry index, channel and the start and goal values of a load.
// Each input word gives exactly one result word on m_axis: the read value
// (zero unless a read hits an in-range slot), the finished flag after the word
// and the music volume held before the word.
// The fade step is written through cfg_wr_en / cfg_wr_data; the user must do
// so only while idle, which the block itself does not enforce. Load, start,
// read and a tick on a finished fade go from acceptance through the result
// state to m_axis_tvalid. A running tick walks every stored channel through
// one shared step unit, one channel a cycle, on the single read and single
// write port of the palette memory. s_axis_tready is high only when idle.
// A finished result sits in the output register; the next word is accepted
// meanwhile and its result waits until the receiver takes the previous one.
// Reset clears the step, volume, finished flag and handshake state; palette
// contents are undefined until loaded, and no clearing pass is run.

module palette_fade_engine #(
    parameter int PALETTE_ENTRIES = pfe_pkg::PALETTE_ENTRIES,
    parameter int CHANNELS        = pfe_pkg::CHANNELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // fade_step, signed
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // entry_index, color_channel, start_value, goal_value
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // read_value, fade_done, volume_out
);

    localparam int STORE_DEPTH = PALETTE_ENTRIES * CHANNELS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SLOT_W      = ADDR_W + 2;
    localparam int RAM_W       = 2 * pfe_pkg::VAL_W;

    pfe_pkg::state_t state_reg, state_next;

    logic signed [7:0]            fade_step_reg;
    logic [pfe_pkg::VOL_W-1:0]    vol_reg, vol_next;
    logic                         finished_reg, finished_next;
    logic                         m_valid_reg, m_valid_next;
    logic [15:0]                  m_data_reg, m_data_next;
    logic [pfe_pkg::VOL_W-1:0]    vol_before_reg, vol_before_next;
    logic                         hit_reg, hit_next;
    logic [CNT_W-1:0]             addr_reg, addr_next;
    logic [ADDR_W-1:0]            wb_addr_reg, wb_addr_next;
    logic                         pend_reg, pend_next;
    logic                         still_reg, still_next;

    logic [7:0]                   in_entry;
    logic [1:0]                   in_chan;
    logic [7:0]                   in_start;
    logic [7:0]                   in_goal;
    pfe_pkg::kind_t               in_kind;
    logic                         in_fire;
    logic                         in_range;
    logic [SLOT_W-1:0]            slot_wide;
    logic [ADDR_W-1:0]            slot;
    logic                         issuing;
    logic                         out_free;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [RAM_W-1:0]             ram_wdata;
    logic                         ram_re;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [RAM_W-1:0]             ram_rdata;

    pfe_pkg::chan_result_t        step_res;
    logic signed [8:0]            vol_sum;
    logic [7:0]                   read_value;

    assign in_entry = s_axis_tdata[7:0];
    assign in_chan  = s_axis_tdata[9:8];
    assign in_start = s_axis_tdata[17:10];
    assign in_goal  = s_axis_tdata[25:18];
    assign in_kind  = pfe_pkg::kind_t'(s_axis_tuser);

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_range = (32'(in_entry) < PALETTE_ENTRIES) && (32'(in_chan) < CHANNELS);
    assign slot_wide = SLOT_W'(in_entry) * SLOT_W'(CHANNELS) + SLOT_W'(in_chan);
    assign slot      = slot_wide[ADDR_W-1:0];
    assign issuing   = (addr_reg != CNT_W'(STORE_DEPTH));
    assign out_free  = !m_valid_reg || m_axis_tready;

    pfe_ram #(
        .WIDTH (RAM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // word layout: target in the upper byte, current in the lower
    pfe_chan_unit u_step (
        .cur  (ram_rdata[7:0]),
        .tgt  (ram_rdata[15:8]),
        .step (fade_step_reg),
        .res  (step_res)
    );

    assign vol_sum    = $signed({2'b00, vol_reg}) + $signed({fade_step_reg[7], fade_step_reg});
    assign read_value = hit_reg ? ram_rdata[7:0] : 8'd0;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfe_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (in_kind == pfe_pkg::KIND_TICK && !finished_reg) begin
                        state_next = pfe_pkg::ST_SWEEP;
                    end else begin
                        state_next = pfe_pkg::ST_RESULT;
                    end
                end
            end
            pfe_pkg::ST_SWEEP: begin
                if (!issuing && pend_reg) begin
                    state_next = pfe_pkg::ST_VOL;
                end
            end
            pfe_pkg::ST_VOL: begin
                state_next = pfe_pkg::ST_RESULT;
            end
            pfe_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = pfe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_axis_tready   = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = slot;
        ram_wdata       = {in_goal, in_start};
        ram_re          = 1'b0;
        ram_raddr       = slot;
        vol_next        = vol_reg;
        finished_next   = finished_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        vol_before_next = vol_before_reg;
        hit_next        = hit_reg;
        addr_next       = addr_reg;
        wb_addr_next    = wb_addr_reg;
        pend_next       = 1'b0;
        still_next      = still_reg;
        unique case (state_reg)
            pfe_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_fire) begin
                    vol_before_next = vol_reg;
                    hit_next        = 1'b0;
                    addr_next       = '0;
                    still_next      = 1'b1;
                    unique case (in_kind)
                        pfe_pkg::KIND_LOAD: begin
                            ram_we = in_range;
                        end
                        pfe_pkg::KIND_START: begin
                            finished_next = 1'b0;
                        end
                        pfe_pkg::KIND_TICK: begin
                        end
                        pfe_pkg::KIND_READ: begin
                            ram_re   = in_range;
                            hit_next = in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pfe_pkg::ST_SWEEP: begin
                // read slot n while slot n-1 is written back
                ram_re       = issuing;
                ram_raddr    = addr_reg[ADDR_W-1:0];
                pend_next    = issuing;
                wb_addr_next = addr_reg[ADDR_W-1:0];
                if (issuing) begin
                    addr_next = addr_reg + 1'b1;
                end
                if (pend_reg) begin
                    ram_we     = 1'b1;
                    ram_waddr  = wb_addr_reg;
                    ram_wdata  = {ram_rdata[15:8], step_res.value};
                    still_next = still_reg && !step_res.moved;
                end
            end
            pfe_pkg::ST_VOL: begin
                if (vol_sum > $signed({2'b00, pfe_pkg::VOLUME_FULL})) begin
                    vol_next      = pfe_pkg::VOLUME_FULL;
                    finished_next = still_reg;
                end else if (vol_sum[8]) begin
                    vol_next      = '0;
                    finished_next = still_reg;
                end else begin
                    vol_next      = vol_sum[pfe_pkg::VOL_W-1:0];
                    finished_next = 1'b0;
                end
            end
            pfe_pkg::ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {vol_before_reg, finished_reg, read_value};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pfe_pkg::ST_IDLE;
            fade_step_reg <= '0;
            vol_reg       <= '0;
            finished_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vol_reg      <= vol_next;
            finished_reg <= finished_next;
            m_valid_reg  <= m_valid_next;
            pend_reg     <= pend_next;
            if (cfg_wr_en) begin
                fade_step_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg     <= m_data_next;
        vol_before_reg <= vol_before_next;
        hit_reg        <= hit_next;
        addr_reg       <= addr_next;
        wb_addr_reg    <= wb_addr_next;
        still_reg      <= still_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

/* rtl/pfe_ram.sv */
`timescale 1ns / 1ps

module pfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pfe_chan_unit.sv */
`timescale 1ns / 1ps

module pfe_chan_unit (
    input  logic [pfe_pkg::VAL_W-1:0] cur,
    input  logic [pfe_pkg::VAL_W-1:0] tgt,
    input  logic signed [7:0]         step,
    output pfe_pkg::chan_result_t     res
);

    logic [7:0] mag;
    logic [7:0] diff;

    always_comb begin
        mag  = step[7] ? (8'd0 - step) : step;
        diff = (cur > tgt) ? (cur - tgt) : (tgt - cur);
        if (diff == 8'd0) begin
            res.value = cur;
            res.moved = 1'b0;
        end else if (diff < mag) begin
            // close enough: snap onto the target
            res.value = tgt;
            res.moved = 1'b0;
        end else begin
            res.value = cur + step;
            res.moved = 1'b1;
        end
    end

endmodule

/* rtl/pfe_checker.sv */
`timescale 1ns / 1ps
`include "palette_fade_engine_macros.svh"

module pfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result word stays put
    `PFE_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `PFE_ASSERT_NEXT(a_out_stable, aclk, !aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // volume never leaves its clamped range
    `PFE_ASSERT_NOW(a_vol_range, aclk, !aresetn, m_axis_tvalid, m_axis_tdata[15:9] <= 7'd100)

    // reset empties the output register and frees the input side
    `PFE_ASSERT_NEXT(a_reset_clear, aclk, 1'b0, !aresetn, !m_axis_tvalid && s_axis_tready)

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
